/* rtl/assert_macros.svh */
// assertion macros used by the rtl module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define FLA_ASSERT(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// implication checked from the next edge on
`define FLA_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fla_pkg.sv */
// types and constants for the free list allocator
package fla_pkg;

	localparam int MEM_BYTES   = 1024;
	localparam int MAX_REGIONS = 64;
	localparam int AW          = 6;
	localparam int CW          = 7;
	localparam int SAW         = 10;
	localparam int SZW         = 11;
	localparam int STW         = 16;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FIND,
		S_MOVE,
		S_PUT,
		S_STAT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             action;
		logic [SAW-1:0]   req_start;
		logic [SZW-1:0]   req_size;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [SAW-1:0]   alloc_addr;
		logic [CW-1:0]    region_count;
		logic [STW-1:0]   total_free;
		logic [SZW-1:0]   largest_free;
		logic [STW-1:0]   ok_count;
		logic [STW-1:0]   miss_count;
	} rsp_t;

	typedef struct packed {
		logic [SAW-1:0]   start;
		logic [SZW-1:0]   size;
	} entry_t;

endpackage

/* rtl/free_list_fit_allocator.sv */
// free list allocator: region table in one memory, scanned and shifted per request
// each request runs a search pass over the regions (skipped for a free into a full table),
// a shift of up to 63 entries where needed, and a statistics pass over the table after the step
// one request at a time: input is ready only while idle; single memory read port
// after reset the init state writes entry 0 with the whole memory, then input opens
// reset clears control, counters and the policy register; other table entries are undefined
`include "assert_macros.svh"

module free_list_fit_allocator import fla_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  req_t   in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output rsp_t   out_data,
	input  logic   cfg_we,
	input  logic   cfg_wdata
);

	state_t           state_q, state_d;
	entry_t           mem [MAX_REGIONS];
	entry_t           rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	entry_t           mem_wd;

	logic             policy_q;
	req_t             req_q;
	logic [CW-1:0]    total_q;
	logic [STW-1:0]   good_q, bad_q;
	logic [1:0]       status_q;
	logic [SAW-1:0]   addr_q;

	logic [CW-1:0]    cnt_q, lim_q;
	logic             down_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	logic             iss, phase_end;

	logic             found_q;
	logic [AW-1:0]    pick_q;
	entry_t           pick_e_q;
	logic [CW-1:0]    pos_q;

	logic [STW-1:0]   sum_q;
	logic [SZW-1:0]   larg_q;
	logic [STW:0]     sum_wide;

	rsp_t             out_q;
	logic             out_valid_q;
	logic             out_load;
	logic             is_free;
	logic             exact;

	// scan control
	assign iss       = (state_q == S_FIND || state_q == S_MOVE || state_q == S_STAT)
		&& (cnt_q != lim_q);
	assign phase_end = !iss && !vld_s1;
	assign is_free   = (req_q.action == ACT_FREE);
	assign exact     = (pick_e_q.size == req_q.req_size);
	assign sum_wide  = {1'b0, sum_q} + {{(STW+1-SZW){1'b0}}, rd_q.size};
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory write port
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		case (state_q)
			S_INIT: begin
				mem_we        = 1'b1;
				mem_wd.size   = SZW'(MEM_BYTES);
				state_d       = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.action == ACT_FREE && total_q >= CW'(MAX_REGIONS)) begin
						state_d = S_STAT;
					end else begin
						state_d = S_FIND;
					end
				end
			end
			S_FIND: begin
				if (phase_end) begin
					if (is_free) begin
						state_d = S_MOVE;
					end else if (!found_q) begin
						state_d = S_STAT;
					end else if (exact) begin
						state_d = S_MOVE;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_MOVE: begin
				mem_we = vld_s1;
				mem_wa = down_q ? idx_s1 + AW'(1) : idx_s1 - AW'(1);
				mem_wd = rd_q;
				if (phase_end) begin
					state_d = is_free ? S_PUT : S_STAT;
				end
			end
			S_PUT: begin
				mem_we = 1'b1;
				if (is_free) begin
					mem_wa       = pos_q[AW-1:0];
					mem_wd.start = req_q.req_start;
					mem_wd.size  = req_q.req_size;
				end else begin
					mem_wa       = pick_q;
					mem_wd.start = pick_e_q.start + req_q.req_size[SAW-1:0];
					mem_wd.size  = pick_e_q.size - req_q.req_size;
				end
				state_d = S_STAT;
			end
			S_STAT: begin
				if (phase_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// region memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[cnt_q[AW-1:0]];
	end

	// request datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= 1'b0;
			total_q     <= CW'(1);
			good_q      <= '0;
			bad_q       <= '0;
			cnt_q       <= '0;
			lim_q       <= '0;
			down_q      <= 1'b0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end

			// read issue pipeline
			vld_s1 <= iss;
			idx_s1 <= cnt_q[AW-1:0];
			if (iss) begin
				cnt_q <= down_q ? cnt_q - CW'(1) : cnt_q + CW'(1);
			end

			// statistics accumulation, held until the result register loads
			if (state_q == S_IDLE) begin
				sum_q  <= '0;
				larg_q <= '0;
			end else if (state_q == S_STAT && vld_s1) begin
				sum_q  <= sum_wide[STW] ? {STW{1'b1}} : sum_wide[STW-1:0];
				if (rd_q.size > larg_q) begin
					larg_q <= rd_q.size;
				end
			end

			// search pass
			if (state_q == S_FIND && vld_s1) begin
				if (is_free) begin
					if (idx_s1 == '0) begin
						if (req_q.req_start < rd_q.start) begin
							pos_q   <= '0;
							found_q <= 1'b1;
						end
					end else if (!found_q && rd_q.start >= req_q.req_start) begin
						pos_q   <= {1'b0, idx_s1};
						found_q <= 1'b1;
					end
				end else if (rd_q.size >= req_q.req_size) begin
					if (!found_q || (policy_q && rd_q.size < pick_e_q.size)) begin
						pick_q   <= idx_s1;
						pick_e_q <= rd_q;
						found_q  <= 1'b1;
					end
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q    <= in_data;
						addr_q   <= '0;
						found_q  <= 1'b0;
						pos_q    <= total_q;
						down_q   <= 1'b0;
						cnt_q    <= '0;
						lim_q    <= total_q;
						status_q <= (in_data.action == ACT_FREE
							&& total_q >= CW'(MAX_REGIONS)) ? ST_FULL : ST_DONE;
					end
				end
				S_FIND: begin
					if (phase_end) begin
						if (is_free) begin
							down_q <= 1'b1;
							cnt_q  <= total_q - CW'(1);
							lim_q  <= pos_q - CW'(1);
						end else if (!found_q) begin
							status_q <= ST_NOFIT;
							bad_q    <= (bad_q == {STW{1'b1}}) ? bad_q : bad_q + STW'(1);
							cnt_q    <= '0;
							lim_q    <= total_q;
						end else begin
							addr_q <= pick_e_q.start;
							good_q <= (good_q == {STW{1'b1}}) ? good_q : good_q + STW'(1);
							if (exact) begin
								cnt_q   <= {1'b0, pick_q} + CW'(1);
								lim_q   <= total_q;
								total_q <= total_q - CW'(1);
							end
						end
					end
				end
				S_MOVE: begin
					if (phase_end && !is_free) begin
						down_q <= 1'b0;
						cnt_q  <= '0;
						lim_q  <= total_q;
					end
				end
				S_PUT: begin
					down_q <= 1'b0;
					cnt_q  <= '0;
					if (is_free) begin
						total_q <= total_q + CW'(1);
						lim_q   <= total_q + CW'(1);
					end else begin
						lim_q <= total_q;
					end
				end
				default: begin
				end
			endcase

			// result register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.status        <= status_q;
			out_q.alloc_addr    <= addr_q;
			out_q.region_count  <= total_q;
			out_q.total_free    <= sum_q;
			out_q.largest_free  <= larg_q;
			out_q.ok_count      <= good_q;
			out_q.miss_count    <= bad_q;
		end
	end

	// checks
	`FLA_ASSERT(a_total_max, clk, arst_n, total_q <= CW'(MAX_REGIONS), "region count overflow")
	`FLA_ASSERT_NEXT(a_load_done, clk, arst_n, !out_valid_q && state_q != S_DONE, !out_valid_q, "result without done state")
	`FLA_ASSERT(a_write_idle, clk, arst_n, mem_we |-> (state_q != S_IDLE && state_q != S_FIND && state_q != S_STAT), "memory write outside update states")
	`FLA_ASSERT_NEXT(a_total_step, clk, arst_n, state_q == S_IDLE, total_q == $past(total_q), "region count moved while idle")

endmodule

/* tb/free_list_fit_allocator_test.sv */
// testbench for the free list allocator: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module free_list_fit_allocator_test;
	import fla_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 150;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	// shadow copy of the region table
	logic [SAW-1:0] shadow_start [MAX_REGIONS];
	logic [SZW-1:0] shadow_size [MAX_REGIONS];
	int             shadow_count;
	logic [STW-1:0] shadow_good;
	logic [STW-1:0] shadow_bad;
	logic           shadow_policy;

	rsp_t pending_rsp [$];
	int   mismatches = 0;
	int   idle_cycles = 0;
	bit   quiet = 1'b0;
	bit   hold_req = 1'b0;

	free_list_fit_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one request to the shadow table and return the response it should produce
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int i, pick, pos, sum;
		bit found;
		logic [SZW-1:0] big;
		o = '0;
		if (r.action == ACT_ALLOC) begin
			found = 1'b0;
			pick = 0;
			for (i = 0; i < shadow_count; i++) begin
				if (shadow_size[i] >= r.req_size && !(found && shadow_policy == 1'b0)) begin
					if (!found || shadow_size[i] < shadow_size[pick]) begin
						pick = i;
						found = 1'b1;
					end
				end
			end
			if (!found) begin
				o.status = ST_NOFIT;
				if (shadow_bad != 16'hFFFF) shadow_bad++;
			end else begin
				o.status = ST_DONE;
				o.alloc_addr = shadow_start[pick];
				if (shadow_size[pick] == r.req_size) begin
					for (i = pick; i + 1 < shadow_count; i++) begin
						shadow_start[i] = shadow_start[i + 1];
						shadow_size[i] = shadow_size[i + 1];
					end
					shadow_count--;
				end else begin
					shadow_start[pick] = shadow_start[pick] + r.req_size[SAW-1:0];
					shadow_size[pick] = shadow_size[pick] - r.req_size;
				end
				if (shadow_good != 16'hFFFF) shadow_good++;
			end
		end else if (shadow_count >= MAX_REGIONS) begin
			o.status = ST_FULL;
		end else begin
			o.status = ST_DONE;
			if (shadow_count == 0 || r.req_start < shadow_start[0]) begin
				pos = 0;
			end else begin
				pos = 1;
				while (pos < shadow_count && shadow_start[pos] < r.req_start) pos++;
			end
			for (i = shadow_count; i > pos; i--) begin
				shadow_start[i] = shadow_start[i - 1];
				shadow_size[i] = shadow_size[i - 1];
			end
			shadow_start[pos] = r.req_start;
			shadow_size[pos] = r.req_size;
			shadow_count++;
		end
		// statistics over the table after the step
		sum = 0;
		big = '0;
		for (i = 0; i < shadow_count; i++) begin
			sum += shadow_size[i];
			if (sum > 65535) sum = 65535;
			if (shadow_size[i] > big) big = shadow_size[i];
		end
		o.region_count = shadow_count[CW-1:0];
		o.total_free = sum[STW-1:0];
		o.largest_free = big;
		o.ok_count = shadow_good;
		o.miss_count = shadow_bad;
		return o;
	endfunction

	// request transfer, with optional idle burst ahead of it
	task automatic send_req(input logic act, input logic [SAW-1:0] st, input logic [SZW-1:0] sz);
		int gap;
		req_t r;
		r.action = act;
		r.req_start = st;
		r.req_size = sz;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		pending_rsp.push_back(apply_request(r));
	endtask

	// drop valid and wait for every response plus the block's settle time
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_policy(input logic p);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_policy = p;
	endtask

	task automatic random_req();
		int k;
		logic [SZW-1:0] sz;
		k = $urandom_range(0, 15);
		if (k == 0) sz = SZW'($urandom_range(0, 2047));
		else if (k == 1) sz = SZW'($urandom_range(0, 1));
		else sz = SZW'($urandom_range(1, 96));
		send_req(1'($urandom_range(0, 1)), SAW'($urandom_range(0, 1023)), sz);
	endtask

	task automatic test_directed();
		send_req(ACT_ALLOC, 10'd0, 11'd0);
		send_req(ACT_ALLOC, 10'd0, 11'd2047);
		send_req(ACT_ALLOC, 10'd0, 11'd1024);
		send_req(ACT_ALLOC, 10'd0, 11'd5);
		send_req(ACT_FREE, 10'd512, 11'd0);
		send_req(ACT_ALLOC, 10'd0, 11'd0);
		send_req(ACT_FREE, 10'd1023, 11'd1);
		send_req(ACT_FREE, 10'd0, 11'd1024);
		send_req(ACT_FREE, 10'd0, 11'd7);
		send_req(ACT_FREE, 10'd1023, 11'd2047);
		send_req(ACT_FREE, 10'd300, 11'd20);
		send_req(ACT_ALLOC, 10'd0, 11'd1024);
		send_req(ACT_ALLOC, 10'd0, 11'd1);
		send_req(ACT_ALLOC, 10'd0, 11'd2047);
		set_policy(1'b1);
		send_req(ACT_ALLOC, 10'd0, 11'd6);
		send_req(ACT_ALLOC, 10'd0, 11'd20);
		send_req(ACT_ALLOC, 10'd0, 11'd1000);
		send_req(ACT_ALLOC, 10'd0, 11'd0);
		send_req(ACT_FREE, 10'd5, 11'd3);
		send_req(ACT_ALLOC, 10'd0, 11'd3);
		set_policy(1'b0);
	endtask

	task automatic test_full_table();
		while (shadow_count < MAX_REGIONS)
			send_req(ACT_FREE, SAW'($urandom_range(0, 1023)), SZW'($urandom_range(0, 3)));
		send_req(ACT_FREE, 10'd1023, 11'd1024);
		send_req(ACT_FREE, 10'd0, 11'd1);
		send_req(ACT_ALLOC, 10'd0, 11'd0);
		send_req(ACT_ALLOC, 10'd0, 11'd1);
		repeat (70) send_req(ACT_ALLOC, 10'd0, 11'd0);
		send_req(ACT_ALLOC, 10'd0, 11'd0);
	endtask

	task automatic test_random(input int n);
		repeat (n) random_req();
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		repeat (12) random_req();
		drain();
	endtask

	// sender pause until every response is back
	task automatic test_pause();
		repeat (20) random_req();
		drain();
		repeat (20) random_req();
	endtask

	// receiver: random stall bursts, plus a long hold on request
	initial begin
		int burst, held;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hold_req = 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", out_data);
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.status !== want.status || out_data.alloc_addr !== want.alloc_addr
						|| out_data.region_count !== want.region_count
						|| out_data.total_free !== want.total_free
						|| out_data.largest_free !== want.largest_free
						|| out_data.ok_count !== want.ok_count
						|| out_data.miss_count !== want.miss_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: expected %p actual %p", want, out_data);
				end
			end
		end
	end

	// cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("free_list_fit_allocator_test failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			shadow_start[i] = '0;
			shadow_size[i] = '0;
		end
		shadow_size[0] = SZW'(MEM_BYTES);
		shadow_count = 1;
		shadow_good = '0;
		shadow_bad = '0;
		shadow_policy = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_table();
		test_random(300);
		set_policy(1'b1);
		test_random(250);
		test_backpressure();
		test_full_table();
		set_policy(1'b0);
		test_random(200);
		test_pause();
		set_policy(1'b1);
		quiet = 1'b1;
		test_random(120);
		drain();

		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("free_list_fit_allocator_test passed");
		else
			$display("free_list_fit_allocator_test failed");
		$finish;
	end

endmodule
